[rtl/core/dual_stack_shared_array_top_defines.svh]
// Assertion macros for the dual stack block
`ifndef DUAL_STACK_SHARED_ARRAY_TOP_DEFINES_SVH
`define DUAL_STACK_SHARED_ARRAY_TOP_DEFINES_SVH

// antecedent in the same cycle implies consequent
`define DSSA_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dual stack check failed");

// antecedent implies consequent in the next cycle
`define DSSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dual stack check failed");

`endif

[rtl/core/dssa_pkg.sv]
// Shared types and constants for the dual stack block
`timescale 1ns / 1ps
package dssa_pkg;

  localparam int DEPTH_DEF     = 16;
  localparam int WORD_BITS_DEF = 32;
  localparam int OUT_BITS      = 32;

  typedef enum logic [1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2,
    KIND_LIST = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ
  } ctrl_state_t;

  typedef struct packed {
    logic    load_op;
    logic    mem_write;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    rd_start;
    logic    rd_next;
    logic    res_load;
    status_t res_status;
    logic    res_from_mem;
    logic    res_last;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  empty;
    logic  full;
    logic  res_free;
    logic  final_entry;
  } sts_t;

endpackage

[rtl/core/dual_stack_shared_array_top.sv]
// Dual stack in one shared word memory, top level.
// A push or pop loads one result, a peek loads the top word, and a list gives its words
// one per cycle while the output is not stalled, the final one marked by last.
// A new transaction is accepted only in idle, once the previous one has loaded its last
// result; the memory has a single registered read port.
// Reset clears both counts and the result valid flag; memory and result data are not cleared.
`timescale 1ns / 1ps
`include "dual_stack_shared_array_top_defines.svh"
module dual_stack_shared_array_top #(
  parameter int DEPTH     = dssa_pkg::DEPTH_DEF,
  parameter int WORD_BITS = dssa_pkg::WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic               which_stack,
  input  logic signed [31:0] push_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic               last
);
  import dssa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dssa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dssa_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .kind        (kind),
    .which_stack (which_stack),
    .push_value  (push_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_value  (read_value),
    .last        (last),
    .cmd         (cmd),
    .sts         (sts)
  );

  `DSSA_ASSERT_SAME(a_no_write_when_full, clk, rst, cmd.mem_write, !sts.full)
  `DSSA_ASSERT_SAME(a_load_only_when_free, clk, rst, cmd.res_load, sts.res_free)
  `DSSA_ASSERT_SAME(a_no_accept_mid_list, clk, rst, cmd.rd_next, !in_ready)
  `DSSA_ASSERT_NEXT(a_load_shows_result, clk, rst, cmd.res_load, out_valid)

endmodule

[rtl/core/dssa_ctrl.sv]
// Controller state machine for the dual stack block
`timescale 1ns / 1ps
module dssa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dssa_pkg::sts_t sts,
  output dssa_pkg::cmd_t cmd
);
  import dssa_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_status = ST_OK;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_op = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (sts.kind)
          KIND_PUSH: begin
            if (sts.res_free) begin
              cmd.res_load = 1'b1;
              cmd.res_last = 1'b1;
              if (sts.full) begin
                cmd.res_status = ST_OVERFLOW;
              end else begin
                cmd.mem_write = 1'b1;
                cmd.cnt_inc   = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          KIND_POP: begin
            if (sts.res_free) begin
              cmd.res_load = 1'b1;
              cmd.res_last = 1'b1;
              if (sts.empty) begin
                cmd.res_status = ST_EMPTY;
              end else begin
                cmd.cnt_dec = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          KIND_PEEK, KIND_LIST: begin
            if (!sts.empty) begin
              cmd.rd_start = 1'b1;
              state_next   = S_READ;
            end else if (sts.res_free) begin
              cmd.res_load   = 1'b1;
              cmd.res_last   = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_next     = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_READ: begin
        if (sts.res_free) begin
          cmd.res_load     = 1'b1;
          cmd.res_from_mem = 1'b1;
          cmd.res_last     = (sts.kind == KIND_PEEK) || sts.final_entry;
          if (cmd.res_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[rtl/core/dssa_dp.sv]
// Datapath for the dual stack block: word memory, counts, result register
`timescale 1ns / 1ps
module dssa_dp #(
  parameter int DEPTH     = dssa_pkg::DEPTH_DEF,
  parameter int WORD_BITS = dssa_pkg::WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [1:0]            kind,
  input  logic                  which_stack,
  input  logic signed [31:0]    push_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic signed [31:0]    read_value,
  output logic                  last,
  input  dssa_pkg::cmd_t        cmd,
  output dssa_pkg::sts_t        sts
);
  import dssa_pkg::*;

  localparam int HALF      = DEPTH / 2;
  localparam int UP_BASE   = HALF + 1;
  localparam int CAP_LOWER = HALF + 1;
  localparam int CAP_UPPER = DEPTH - UP_BASE;
  localparam int AW        = $clog2(DEPTH);
  localparam int IW        = AW + 2;
  localparam int CW        = $clog2(DEPTH + 1);
  localparam int LCW       = $clog2(CAP_LOWER + 1);
  localparam int UCW       = $clog2(CAP_UPPER + 1);

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata;

  kind_t                op_kind;
  logic                 op_which;
  logic [WORD_BITS-1:0] op_word;
  logic [LCW-1:0]       lower_count;
  logic [UCW-1:0]       upper_count;
  logic [CW-1:0]        d;

  logic [CW-1:0]        n;
  logic [CW-1:0]        d_sel;
  logic [IW-1:0]        waddr_full;
  logic [IW-1:0]        raddr_full;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [63:0]          rdata_ext;

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_kind  <= kind_t'(kind);
      op_which <= which_stack;
      op_word  <= WORD_BITS'(push_value);
    end
  end

  always_comb begin
    n = op_which ? CW'(upper_count) : CW'(lower_count);
    d_sel = cmd.rd_start ? '0 : d + CW'(1);
    if (op_which) begin
      waddr_full = IW'(UP_BASE) + IW'(n);
      raddr_full = IW'(UP_BASE) + IW'(n) - IW'(1) - IW'(d_sel);
    end else begin
      waddr_full = IW'(HALF) - IW'(n);
      raddr_full = IW'(HALF) - IW'(n) + IW'(1) + IW'(d_sel);
    end
    waddr = waddr_full[AW-1:0];
    raddr = raddr_full[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_write) begin
      mem[waddr] <= op_word;
    end
    if (cmd.rd_start || cmd.rd_next) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_count <= '0;
      upper_count <= '0;
    end else if (op_which) begin
      if (cmd.cnt_inc) begin
        upper_count <= upper_count + UCW'(1);
      end else if (cmd.cnt_dec) begin
        upper_count <= upper_count - UCW'(1);
      end
    end else begin
      if (cmd.cnt_inc) begin
        lower_count <= lower_count + LCW'(1);
      end else if (cmd.cnt_dec) begin
        lower_count <= lower_count - LCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_start) begin
      d <= '0;
    end else if (cmd.rd_next) begin
      d <= d + CW'(1);
    end
  end

  assign rdata_ext = 64'(signed'(rdata));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      status     <= cmd.res_status;
      read_value <= cmd.res_from_mem ? rdata_ext[OUT_BITS-1:0] : '0;
      last       <= cmd.res_last;
    end
  end

  always_comb begin
    sts.kind        = op_kind;
    sts.empty       = (n == '0);
    sts.full        = op_which ? (upper_count == UCW'(CAP_UPPER))
                               : (lower_count == LCW'(CAP_LOWER));
    sts.res_free    = !out_valid || out_ready;
    sts.final_entry = ((d + CW'(1)) == n);
  end

endmodule
